// ----- hw/rtl/ssho_pkg.sv -----
// Package with payload types and curve order constants for the scalar subtract/halve block.
`default_nettype none

package ssho_pkg;

  // Command codes carried in the cmd field.
  localparam logic CMD_SUB   = 1'b0;
  localparam logic CMD_HALVE = 1'b1;

  // Group order r, about 2^254.
  localparam logic [255:0] ORDER = {
    64'h3FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
    64'h9D0C930F54078C53, 64'h1F52C8AE74D84525
  };

  // (r+1)/2, the inverse of two modulo r.
  localparam logic [255:0] HALF_INV = {
    64'h1FFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
    64'hCE864987AA03C629, 64'h8FA964573A6C2293
  };

  // Multiples of r used by the reduction steps; r < 2^254 so they fit 256 bits.
  localparam logic [255:0] ORDER_X2 = {ORDER[254:0], 1'b0};
  localparam logic [255:0] ORDER_X4 = {ORDER[253:0], 2'b00};

  // 8r as a 259-bit value, and 8r - 2^256, which is added to a wrapped
  // 256-bit difference after a borrow to give a - b + 8r exactly.
  localparam logic [258:0] ORDER_X8 = {ORDER, 3'b000};
  localparam logic [256:0] ORDER_X8_WRAP = 257'(ORDER_X8 - (259'd1 << 256));

  typedef struct packed {
    logic        cmd;
    logic [63:0] a_limb0;
    logic [63:0] a_limb1;
    logic [63:0] a_limb2;
    logic [63:0] a_limb3;
    logic [63:0] b_limb0;
    logic [63:0] b_limb1;
    logic [63:0] b_limb2;
    logic [63:0] b_limb3;
  } req_t;

  typedef struct packed {
    logic [63:0] d_limb0;
    logic [63:0] d_limb1;
    logic [63:0] d_limb2;
    logic [63:0] d_limb3;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/scalar_sub_half_mod_order.sv -----
// Top level: pipelined subtract or halve modulo the curve group order r.
//
// Usage: one request beat on req carries a command and two 256-bit scalars
// a and b as 64-bit little-endian limbs. Subtract returns (a - b) mod r and
// halve returns a * (1/2) mod r; b is ignored for halve. Every request gives
// exactly one response beat on rsp, fully reduced into [0, r), in order.
// Both channels use valid/ready; a beat moves when valid and ready are high.
//
// The datapath is five register stages, each holding one 257-bit add or
// subtract: form the difference or the shifted value, add the offset
// (8r after a borrow, (r+1)/2 for an odd halve), then conditionally subtract
// 4r, 2r and r. One beat per cycle is sustained while the receiver keeps
// rsp_ready high.
//
// Reset clears all stage valid bits, so the pipeline comes up empty and
// req_ready is high. When the receiver stalls, the response stays in the
// output register and each stage holds only while the one after it is full;
// empty stages keep filling, so up to five beats are held before req_ready
// drops. Nothing is lost or repeated across a stall.
`default_nettype none

module scalar_sub_half_mod_order (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_ready,
  input  wire ssho_pkg::req_t req,
  output logic           rsp_valid,
  input  wire            rsp_ready,
  output ssho_pkg::rsp_t rsp
);
  import ssho_pkg::*;

  // Stage valid bits and load enables.
  logic p1_vld, p2_vld, p3_vld, p4_vld;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage payloads.
  logic         p1_cmd;
  logic         p1_flag;   // borrow for subtract, odd bit for halve
  logic [255:0] p1_x;
  logic [256:0] p2_v;      // below 8r
  logic [255:0] p3_v;      // below 4r
  logic [255:0] p4_v;      // below 2r
  logic [255:0] p5_v;      // below r

  // Stage one arithmetic.
  logic [255:0] a_val, b_val;
  logic [256:0] diff;
  logic [255:0] p1_x_next;
  logic         p1_flag_next;

  // Stage two to five arithmetic.
  logic [256:0] offset;
  logic [256:0] p2_v_next;
  logic [257:0] t3;
  logic [256:0] t4, t5;

  // A stage may load when it is empty or its item moves on this cycle.
  always_comb begin
    rdy5 = !rsp_valid || rsp_ready;
    rdy4 = !p4_vld || rdy5;
    rdy3 = !p3_vld || rdy4;
    rdy2 = !p2_vld || rdy3;
    rdy1 = !p1_vld || rdy2;
  end

  assign req_ready = rdy1;

  always_comb begin
    a_val = {req.a_limb3, req.a_limb2, req.a_limb1, req.a_limb0};
    b_val = {req.b_limb3, req.b_limb2, req.b_limb1, req.b_limb0};
    diff  = {1'b0, a_val} - {1'b0, b_val};
    case (req.cmd)
      CMD_SUB: begin
        p1_x_next    = diff[255:0];
        p1_flag_next = diff[256];
      end
      CMD_HALVE: begin
        p1_x_next    = {1'b0, a_val[255:1]};
        p1_flag_next = a_val[0];
      end
      default: begin
        p1_x_next    = '0;
        p1_flag_next = 1'b0;
      end
    endcase
  end

  // After a borrow the wrapped difference plus (8r - 2^256) is a - b + 8r.
  always_comb begin
    if (!p1_flag) begin
      offset = '0;
    end else if (p1_cmd == CMD_HALVE) begin
      offset = {1'b0, HALF_INV};
    end else begin
      offset = ORDER_X8_WRAP;
    end
    p2_v_next = {1'b0, p1_x} + offset;
  end

  always_comb begin
    t3 = {1'b0, p2_v} - {2'b00, ORDER_X4};
    t4 = {1'b0, p3_v} - {1'b0, ORDER_X2};
    t5 = {1'b0, p4_v} - {1'b0, ORDER};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld    <= 1'b0;
      p2_vld    <= 1'b0;
      p3_vld    <= 1'b0;
      p4_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rdy1) p1_vld    <= req_valid;
      if (rdy2) p2_vld    <= p1_vld;
      if (rdy3) p3_vld    <= p2_vld;
      if (rdy4) p4_vld    <= p3_vld;
      if (rdy5) rsp_valid <= p4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && req_valid) begin
      p1_cmd  <= req.cmd;
      p1_flag <= p1_flag_next;
      p1_x    <= p1_x_next;
    end
    if (rdy2 && p1_vld) begin
      p2_v <= p2_v_next;
    end
    if (rdy3 && p2_vld) begin
      p3_v <= t3[257] ? p2_v[255:0] : t3[255:0];
    end
    if (rdy4 && p3_vld) begin
      p4_v <= t4[256] ? p3_v : t4[255:0];
    end
    if (rdy5 && p4_vld) begin
      p5_v <= t5[256] ? p4_v : t5[255:0];
    end
  end

  assign rsp.d_limb0 = p5_v[63:0];
  assign rsp.d_limb1 = p5_v[127:64];
  assign rsp.d_limb2 = p5_v[191:128];
  assign rsp.d_limb3 = p5_v[255:192];

`ifndef SYNTHESIS
  // Every delivered result is fully reduced.
  a_rsp_reduced: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (p5_v < ORDER))
    else $error("response not below the group order");

  // The offset stage never leaves a value at or above 8r.
  a_p2_range: assert property (@(posedge clk) disable iff (rst)
    p2_vld |-> ({2'b00, p2_v} < ORDER_X8))
    else $error("offset stage value out of range");

  // The 2r reduction step keeps its value below 2r.
  a_p4_range: assert property (@(posedge clk) disable iff (rst)
    p4_vld |-> (p4_v < ORDER_X2))
    else $error("reduction stage value out of range");

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!rsp_valid && !p1_vld))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_scalar_sub_half_mod_order.sv -----
// Self-checking bench for the pipelined subtract/halve modulo the curve group order block.
`timescale 1ns / 1ps

module tb_scalar_sub_half_mod_order;
  import ssho_pkg::*;

  // Directed beats come first, then three phases of random beats.
  localparam int PHASE_BEATS = 643;
  // A single long receiver hold-off. It is far longer than the five-stage pipeline
  // needs to fill and drop req_ready.
  localparam int LONG_HOLD = 300;
  // The slowest correct run uses about 1950 beats, plus the drains and the
  // long hold. The limit leaves a wide margin on top.
  localparam int CYCLE_LIMIT = 200000;
  // Settle time after the last response.
  localparam int TAIL_CYCLES = 20;
  // Cap on mismatch lines, so that a broken build cannot flood the log.
  localparam int REPORT_CAP = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Inputs of the block start at known values before the first edge.
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Stimulus and scoreboard state.
  req_t pending_beats[$];
  rsp_t expected_residues[$];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_trigger = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  rsp_t oldest;

  scalar_sub_half_mod_order dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected residue for one request beat. The working value is kept wide
  // enough for a - b + 8r. The reduction then takes off 4r, 2r and r
  // conditionally, in that order. This reduces anything below 8r fully.
  function automatic rsp_t residue_of(req_t beat);
    logic [255:0] a;
    logic [255:0] b;
    logic [259:0] v;
    logic [259:0] step;
    int s;
    a = {beat.a_limb3, beat.a_limb2, beat.a_limb1, beat.a_limb0};
    b = {beat.b_limb3, beat.b_limb2, beat.b_limb1, beat.b_limb0};
    if (beat.cmd == CMD_SUB) begin
      // On a borrow, adding 8r keeps the difference nonnegative.
      if (a < b) begin
        v = {4'b0, a} + ({1'b0, ORDER, 3'b000}) - {4'b0, b};
      end else begin
        v = {4'b0, a} - {4'b0, b};
      end
    end else begin
      // Halving: floor(a/2), plus (r+1)/2 when a is odd. Operand b plays no part.
      v = {5'b0, a[255:1]};
      if (a[0]) begin
        v = v + {4'b0, HALF_INV};
      end
    end
    for (s = 2; s >= 0; s--) begin
      step = {4'b0, ORDER} << s;
      if (v >= step) begin
        v = v - step;
      end
    end
    return '{d_limb0: v[63:0], d_limb1: v[127:64], d_limb2: v[191:128],
             d_limb3: v[255:192]};
  endfunction

  function automatic req_t make_beat(logic op, logic [255:0] a, logic [255:0] b);
    return '{cmd: op,
             a_limb0: a[63:0], a_limb1: a[127:64], a_limb2: a[191:128],
             a_limb3: a[255:192],
             b_limb0: b[63:0], b_limb1: b[127:64], b_limb2: b[191:128],
             b_limb3: b[255:192]};
  endfunction

  // A random 256-bit operand with several shapes: fully random, already
  // reduced, close to a small multiple of r, limbs forced to all zeros or all
  // ones, and small values.
  function automatic logic [255:0] rand_scalar();
    logic [255:0] x;
    int i;
    x = {$urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom()};
    case ($urandom_range(4))
      0: begin
      end
      1: begin
        x = x % ORDER;
      end
      2: begin
        x = ORDER * 256'($urandom_range(1, 4)) + 256'($urandom_range(8)) - 256'd4;
      end
      3: begin
        for (i = 0; i < 4; i++) begin
          case ($urandom_range(2))
            0: x[64*i +: 64] = '0;
            1: x[64*i +: 64] = '1;
            default: begin
            end
          endcase
        end
      end
      default: begin
        x = 256'($urandom());
      end
    endcase
    return x;
  endfunction

  task automatic queue_random(int count);
    logic [255:0] a;
    logic [255:0] b;
    logic op;
    int n;
    for (n = 0; n < count; n++) begin
      op = logic'($urandom_range(1));
      a = rand_scalar();
      b = rand_scalar();
      // Equal and near-equal operands sit right at the borrow boundary.
      case ($urandom_range(9))
        0: b = a;
        1: b = a + 256'd1;
        default: begin
        end
      endcase
      pending_beats.push_back(make_beat(op, a, b));
    end
  endtask

  // The sender stops offering once its queue is empty. This task waits until
  // every beat is accepted and every expected response has come back. It
  // samples on the falling edge, clear of the driver's updates.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_beats.size() != 0 || req_valid || expected_residues.size() != 0);
  endtask

  task automatic check_limb(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Request driver. A beat that is offered stays on the bus unchanged until it
  // is accepted. Otherwise the driver offers the next queued beat, unless it
  // chooses to idle this cycle.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else if (!req_valid || req_ready) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_valid <= 1'b1;
        req <= pending_beats.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response receiver. Random stalls, plus one long hold-off that is started
  // once when hold_trigger rises. The hold is counted here, in this process.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trigger && !hold_done) begin
      rsp_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor and scoreboard. A response beat is checked against the oldest
  // expectation before a request beat accepted at the same edge adds its own.
  // Each request passes through the stage registers before the response
  // register, so no response can belong to a request accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_residues.size() == 0) begin
          if (mismatches < REPORT_CAP) begin
            $display("%0t: response beat with none expected, actual %h", $time, rsp);
          end
          mismatches++;
        end else begin
          oldest = expected_residues.pop_front();
          check_limb("d_limb0", oldest.d_limb0, rsp.d_limb0);
          check_limb("d_limb1", oldest.d_limb1, rsp.d_limb1);
          check_limb("d_limb2", oldest.d_limb2, rsp.d_limb2);
          check_limb("d_limb3", oldest.d_limb3, rsp.d_limb3);
        end
      end
      if (req_valid && req_ready) begin
        expected_residues.push_back(residue_of(req));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("scalar_sub_half_mod_order test failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Phase one: the sender idles often and the receiver stalls very often.
    send_idle_pct = 35;
    recv_stall_pct = 77;

    // Directed subtract beats: extremes, exact multiples of r, a borrow at
    // both ends of its range, and alternating limb patterns.
    pending_beats.push_back(make_beat(CMD_SUB, '0, '0));
    pending_beats.push_back(make_beat(CMD_SUB, '1, '1));
    pending_beats.push_back(make_beat(CMD_SUB, '1, '0));
    pending_beats.push_back(make_beat(CMD_SUB, '0, '1));
    pending_beats.push_back(make_beat(CMD_SUB, ORDER, '0));
    pending_beats.push_back(make_beat(CMD_SUB, ORDER - 256'd1, '0));
    pending_beats.push_back(make_beat(CMD_SUB, '0, 256'd1));
    pending_beats.push_back(make_beat(CMD_SUB, 256'd5, 256'd7));
    pending_beats.push_back(make_beat(CMD_SUB, ORDER_X4, '0));
    pending_beats.push_back(make_beat(CMD_SUB, ORDER_X4 - 256'd1, '0));
    pending_beats.push_back(make_beat(CMD_SUB, ORDER, ORDER + 256'd1));
    pending_beats.push_back(make_beat(CMD_SUB, '0, ORDER));
    pending_beats.push_back(make_beat(CMD_SUB,
        {64'hFFFFFFFFFFFFFFFF, 64'h0, 64'hFFFFFFFFFFFFFFFF, 64'h0},
        {64'h0, 64'hFFFFFFFFFFFFFFFF, 64'h0, 64'hFFFFFFFFFFFFFFFF}));
    pending_beats.push_back(make_beat(CMD_SUB,
        {64'h0, 64'hFFFFFFFFFFFFFFFF, 64'h0, 64'hFFFFFFFFFFFFFFFF},
        {64'hFFFFFFFFFFFFFFFF, 64'h0, 64'hFFFFFFFFFFFFFFFF, 64'h0}));

    // Directed halve beats. These cover even and odd values, the extremes,
    // r itself (which halves to zero), multiples of r, and a nonzero b that
    // must have no effect.
    pending_beats.push_back(make_beat(CMD_HALVE, '0, '1));
    pending_beats.push_back(make_beat(CMD_HALVE, 256'd1, '0));
    pending_beats.push_back(make_beat(CMD_HALVE, 256'd3, '1));
    pending_beats.push_back(make_beat(CMD_HALVE, '1, '0));
    pending_beats.push_back(make_beat(CMD_HALVE, '1 - 256'd1, '1));
    pending_beats.push_back(make_beat(CMD_HALVE, ORDER, '0));
    pending_beats.push_back(make_beat(CMD_HALVE, ORDER - 256'd1, '0));
    pending_beats.push_back(make_beat(CMD_HALVE, ORDER_X2, '0));
    pending_beats.push_back(make_beat(CMD_HALVE, ORDER_X4 + 256'd1, rand_scalar()));

    queue_random(PHASE_BEATS);
    wait_drained();

    // Phase two: the roles swap, with a sparse sender and a mostly ready receiver.
    send_idle_pct = 77;
    recv_stall_pct = 35;
    queue_random(PHASE_BEATS);
    wait_drained();

    // Phase three: neither side idles. Near the start the receiver holds off
    // for a long stretch while the sender keeps offering. The pipeline fills
    // and req_ready must drop without losing or repeating a beat.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(PHASE_BEATS);
    hold_trigger = 1'b1;
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_residues.size() == 0) begin
      $display("scalar_sub_half_mod_order test passed");
    end else begin
      $display("scalar_sub_half_mod_order test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/ssho_pkg.sv
hw/rtl/scalar_sub_half_mod_order.sv
bench/tb_scalar_sub_half_mod_order.sv
